[sv/tqs_pkg.sv]
package tqs_pkg;
  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int IVL_W = 31;
  localparam int SLOT_W = 4;
  localparam int KIND_W = 3;
  localparam logic [IVL_W-1:0] DELAY_MAX = {IVL_W{1'b1}};

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_TICK     = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    K_SCHEDULED = 3'd0,
    K_FIRED     = 3'd1,
    K_DONE      = 3'd2,
    K_FULL      = 3'd3,
    K_CANCELLED = 3'd4
  } kind_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input transaction
    logic do_sched;
    logic do_cancel;
    logic tick;       // advance time
    logic scan_clr;   // start a scan
    logic scan_step;  // examine one slot
    logic fire;       // fire the best slot
    logic emit;       // load output register
    kind_t emit_kind;
    logic emit_last;
  } tqs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;   // last slot examined this cycle
    logic found_due;  // scan found a due slot
    logic have_free;
  } tqs_sts_t;
endpackage

[sv/tqs_datapath.sv]
module tqs_datapath #(
  parameter int NUM_TIMERS = tqs_pkg::NUM_TIMERS_DEF,
  parameter int TIME_WIDTH = tqs_pkg::TIME_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tqs_pkg::tqs_cmd_t           cmd,
  output tqs_pkg::tqs_sts_t           sts,
  input  logic [tqs_pkg::IVL_W-1:0]   interval,
  input  logic                        repeats,
  input  logic [tqs_pkg::SLOT_W-1:0]  slot_to_cancel,
  output logic [tqs_pkg::KIND_W-1:0]  kind,
  output logic [tqs_pkg::SLOT_W-1:0]  slot_id,
  output logic [tqs_pkg::IVL_W-1:0]   next_delay,
  output logic                        last
);
  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TW = TIME_WIDTH;

  logic [TW-1:0] current_time;
  logic [TW-1:0] expiry [NUM_TIMERS];
  logic [tqs_pkg::IVL_W-1:0] period [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] repeat_flag;
  logic [NUM_TIMERS-1:0] slot_active;
  logic [NUM_TIMERS-1:0] fired;

  logic [tqs_pkg::IVL_W-1:0] ivl;
  logic rep;
  logic [tqs_pkg::SLOT_W-1:0] cslot;

  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] best_idx;
  logic [TW-1:0] best_key;
  logic best_due;
  logic have_any;
  logic [TW-1:0] act_key;
  logic have_act;

  logic [IDX_W-1:0] free_idx;
  logic have_free;

  always_comb begin
    free_idx = '0;
    have_free = 1'b0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!slot_active[i]) begin
        free_idx = IDX_W'(i);
        have_free = 1'b1;
      end
    end
  end

  logic [TW-1:0] cur_ft;
  logic [TW-1:0] gap;
  logic [TW-1:0] key;
  logic due;
  logic cand;

  assign cur_ft = expiry[scan_idx];
  assign gap = cur_ft - current_time;
  assign key = {~gap[TW-1], gap[TW-2:0]};
  assign due = (gap == '0) || gap[TW-1];
  assign cand = slot_active[scan_idx] && !fired[scan_idx] && due;

  assign sts.scan_end = (scan_idx == IDX_W'(NUM_TIMERS - 1));
  assign sts.found_due = best_due;
  assign sts.have_free = have_free;

  logic [TW-1:0] bd;
  logic [tqs_pkg::IVL_W-1:0] delay;
  always_comb begin
    bd = {~act_key[TW-1], act_key[TW-2:0]};
    if (!have_act) delay = tqs_pkg::DELAY_MAX;
    else if (bd == '0 || bd[TW-1]) delay = '0;
    else if (TW - 1 > tqs_pkg::IVL_W && |(bd >> tqs_pkg::IVL_W))
      delay = tqs_pkg::DELAY_MAX;
    else delay = tqs_pkg::IVL_W'(bd);
  end

  logic [TW-1:0] ivl_ext;
  assign ivl_ext = TW'({{(TW > tqs_pkg::IVL_W ? TW : tqs_pkg::IVL_W){1'b0}}, ivl});

  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
      slot_active <= '0;
      fired <= '0;
      scan_idx <= '0;
      best_due <= 1'b0;
      have_act <= 1'b0;
    end else begin
      if (cmd.load) begin
        ivl <= (interval == '0) ? tqs_pkg::IVL_W'(1) : interval;
        rep <= repeats;
        cslot <= slot_to_cancel;
        fired <= '0;
      end
      if (cmd.do_sched && have_free) begin
        slot_active[free_idx] <= 1'b1;
        period[free_idx] <= ivl;
        repeat_flag[free_idx] <= rep;
        expiry[free_idx] <= current_time + ivl_ext;
      end
      if (cmd.do_cancel && {{(32 - tqs_pkg::SLOT_W){1'b0}}, cslot} < 32'(NUM_TIMERS))
        slot_active[IDX_W'(cslot)] <= 1'b0;
      if (cmd.tick) current_time <= current_time + TW'(1);
      if (cmd.scan_clr) begin
        scan_idx <= '0;
        best_due <= 1'b0;
        have_act <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_idx <= sts.scan_end ? '0 : scan_idx + IDX_W'(1);
        if (cand && (!best_due || key < best_key)) begin
          best_due <= 1'b1;
          best_key <= key;
          best_idx <= scan_idx;
        end
        if (slot_active[scan_idx] && (!have_act || key < act_key)) begin
          have_act <= 1'b1;
          act_key <= key;
        end
      end
      if (cmd.fire) begin
        fired[best_idx] <= 1'b1;
        if (repeat_flag[best_idx])
          expiry[best_idx] <= expiry[best_idx] +
            TW'({{(TW > tqs_pkg::IVL_W ? TW : tqs_pkg::IVL_W){1'b0}}, period[best_idx]});
        else slot_active[best_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind <= cmd.emit_kind;
      last <= cmd.emit_last;
      unique case (cmd.emit_kind)
        tqs_pkg::K_SCHEDULED: slot_id <= tqs_pkg::SLOT_W'(free_idx);
        tqs_pkg::K_FIRED:     slot_id <= tqs_pkg::SLOT_W'(best_idx);
        tqs_pkg::K_CANCELLED: slot_id <= cslot;
        default:              slot_id <= '0;
      endcase
      next_delay <= (cmd.emit_kind == tqs_pkg::K_DONE) ? delay : '0;
    end
  end

  a_fire_due: assert property (@(posedge clk) disable iff (rst)
    cmd.fire |-> best_due) else $error("fire without due slot");
  a_sched_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.do_sched && have_free) |=> slot_active[$past(free_idx)])
    else $error("schedule did not take slot");
  a_time_step: assert property (@(posedge clk) disable iff (rst)
    cmd.tick |=> current_time == $past(current_time) + TW'(1))
    else $error("time step wrong");
endmodule

[sv/tqs_ctrl.sv]
module tqs_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              operation,
  output logic                    out_valid,
  input  logic                    out_stall,
  output tqs_pkg::tqs_cmd_t       cmd,
  input  tqs_pkg::tqs_sts_t       sts
);
  typedef enum logic [2:0] {
    S_IDLE, S_OP, S_SCAN, S_DECIDE, S_WAIT
  } state_t;

  state_t state;
  tqs_pkg::op_t op;
  logic after_done;   // the pending output ends the transaction
  logic after_fire;   // the pending output is a fire, rescan after

  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.emit_kind = tqs_pkg::K_DONE;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        cmd.scan_clr = in_valid;
      end
      S_OP: begin
        if (out_free) begin
          unique case (op)
            tqs_pkg::OP_SCHEDULE: begin
              cmd.do_sched = 1'b1;
              cmd.emit = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.emit_kind = sts.have_free ? tqs_pkg::K_SCHEDULED : tqs_pkg::K_FULL;
            end
            tqs_pkg::OP_CANCEL: begin
              cmd.do_cancel = 1'b1;
              cmd.emit = 1'b1;
              cmd.emit_last = 1'b1;
              cmd.emit_kind = tqs_pkg::K_CANCELLED;
            end
            tqs_pkg::OP_TICK: cmd.tick = 1'b1;
            default: ;
          endcase
        end
      end
      S_SCAN: cmd.scan_step = 1'b1;
      S_DECIDE: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          if (sts.found_due) begin
            cmd.fire = 1'b1;
            cmd.emit_kind = tqs_pkg::K_FIRED;
          end else begin
            cmd.emit_kind = tqs_pkg::K_DONE;
            cmd.emit_last = 1'b1;
          end
        end
      end
      S_WAIT: cmd.scan_clr = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      op <= tqs_pkg::OP_NONE;
      after_done <= 1'b0;
      after_fire <= 1'b0;
    end else begin
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          op <= tqs_pkg::op_t'(operation);
          state <= S_OP;
        end
        S_OP: if (out_free) begin
          if (op == tqs_pkg::OP_TICK) state <= S_SCAN;
          else state <= S_IDLE;
        end
        S_SCAN: if (sts.scan_end) state <= S_DECIDE;
        S_DECIDE: if (out_free) begin
          state <= sts.found_due ? S_WAIT : S_IDLE;
        end
        S_WAIT: state <= S_SCAN;
        default: state <= S_IDLE;
      endcase
      after_done <= cmd.emit && cmd.emit_last;
      after_fire <= cmd.fire;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd.load) else $error("load while busy");
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free) else $error("output overwritten");
  a_fire_rescan: assert property (@(posedge clk) disable iff (rst)
    after_fire |-> state == S_WAIT) else $error("no rescan after fire");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    after_done |-> state == S_IDLE) else $error("last without idle");
endmodule

[sv/timer_queue_scheduler_unit.sv]
// schedule and cancel: the result is registered from the op state once the output is free
// tick: time step, then a scan of all NUM_TIMERS slots, then a decision that fires the
//   best due slot and rescans, or loads the done result; output stalls hold each step
// transactions: one at a time, the next is accepted once the last result is loaded
// reset: synchronous, clears time, active flags and control; timer slots need no clearing
module timer_queue_scheduler_unit #(
  parameter int NUM_TIMERS = tqs_pkg::NUM_TIMERS_DEF,
  parameter int TIME_WIDTH = tqs_pkg::TIME_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  operation,
  input  logic [tqs_pkg::IVL_W-1:0]   interval,
  input  logic                        repeats,
  input  logic [tqs_pkg::SLOT_W-1:0]  slot_to_cancel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tqs_pkg::KIND_W-1:0]  kind,
  output logic [tqs_pkg::SLOT_W-1:0]  slot_id,
  output logic [tqs_pkg::IVL_W-1:0]   next_delay,
  output logic                        last
);
  tqs_pkg::tqs_cmd_t cmd;
  tqs_pkg::tqs_sts_t sts;

  tqs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .operation,
    .out_valid, .out_stall, .cmd, .sts
  );

  tqs_datapath #(.NUM_TIMERS(NUM_TIMERS), .TIME_WIDTH(TIME_WIDTH)) u_dp (
    .clk, .rst, .cmd, .sts, .interval, .repeats, .slot_to_cancel,
    .kind, .slot_id, .next_delay, .last
  );
endmodule
